### rtl/i8conv_pkg.sv
// Shared types, constants and codes of the int8 direct convolution core.
`default_nettype none

package i8conv_pkg;

  // Default store depths (entries of 8 bits)
  localparam int ACT_DEPTH_DEF = 16384;
  localparam int WGT_DEPTH_DEF = 16384;

  // Saturation limits of the configuration registers
  localparam int MAX_DIM      = 32;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_KERNEL   = 7;

  // Width of internal address and index arithmetic
  localparam int IDX_W = 20;
  // Width of the index multiplier operands
  localparam int MUL_W = 16;

  // Configuration register widths and reset values
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [4:0] CH_RST = 5'd6;
  localparam logic [5:0] H_RST  = 6'd14;
  localparam logic [5:0] W_RST  = 6'd14;
  localparam logic [4:0] M_RST  = 5'd16;
  localparam logic [2:0] R_RST  = 3'd5;
  localparam logic [2:0] S_RST  = 3'd5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CHANNELS = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_IN_WIDTH    = 3'd2,
    REG_FILTERS     = 3'd3,
    REG_KERNEL_ROWS = 3'd4,
    REG_KERNEL_COLS = 3'd5
  } cfg_reg_e;

  // Item actions
  typedef enum logic [1:0] {
    ACT_WRITE_ACT = 2'd0,
    ACT_WRITE_WGT = 2'd1,
    ACT_COMPUTE   = 2'd2
  } action_e;

  // Input item
  typedef struct packed {
    action_e            action;
    logic [13:0]        store_addr;
    logic signed [7:0]  store_value;
    logic [3:0]         out_filter;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] sum;
    logic [13:0]        flat_index;
    logic               request_ok;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

endpackage

`default_nettype wire

### rtl/i8conv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module i8conv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/i8conv_mac.sv
// Shared signed 8x8 multiply-accumulate unit with a registered product.
`default_nettype none

module i8conv_mac
  import i8conv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mac_ctl_t           ctl_i,
  input  wire logic signed [7:0]  act_i,
  input  wire logic signed [7:0]  wgt_i,
  output logic signed [31:0]      acc_o,
  output logic                    busy_o
);

  logic signed [15:0] prod_q, prod_d;
  logic               prod_vld_q;
  logic signed [31:0] acc_q, acc_d;

  // Multiply the operand pair
  assign prod_d = act_i * wgt_i;

  // Accumulate the registered product
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{16{prod_q[15]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.valid & ~ctl_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

`default_nettype wire

### rtl/int8_direct_convolution_core.sv
// Top level: stores, configuration, tap sequencer and result register.
// Load items (activation or weight write) never stall the input.
// A valid compute item runs the index setup steps, then one multiply-accumulate
// per tap on the shared MAC unit with one read per tap from each store, then a
// drain, before its result is loaded into the result register.
// A rejected compute item (out of bounds or bad configuration) goes straight to the result step.
// Asynchronous active-low reset restores register defaults; stores are not cleared.
`default_nettype none

module int8_direct_convolution_core
  import i8conv_pkg::*;
#(
  parameter int ACT_DEPTH = ACT_DEPTH_DEF,
  parameter int WGT_DEPTH = WGT_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ACT_AW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_HW    = 12'b0000_0000_0010,
    ST_RS    = 12'b0000_0000_0100,
    ST_CRS   = 12'b0000_0000_1000,
    ST_WBASE = 12'b0000_0001_0000,
    ST_PQ    = 12'b0000_0010_0000,
    ST_FLAT  = 12'b0000_0100_0000,
    ST_PQOFF = 12'b0000_1000_0000,
    ST_PW    = 12'b0001_0000_0000,
    ST_RUN   = 12'b0010_0000_0000,
    ST_DRAIN = 12'b0100_0000_0000,
    ST_FIN   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [4:0] ch_q, flt_q;
  logic [5:0] ht_q, wd_q;
  logic [2:0] kr_q, kc_q;

  // Saturated dimensions and derived output size
  logic [4:0] c_sat, m_sat;
  logic [5:0] h_sat, w_sat;
  logic [2:0] r_sat, s_sat;
  logic [5:0] p_dim, q_dim;
  logic       cfg_ok, req_ok;

  // Request and sequencing registers
  in_item_t         req_q;
  logic             ok_q, ok_d;
  logic [4:0]       c_cnt_q, c_cnt_d;
  logic [2:0]       r_cnt_q, r_cnt_d;
  logic [2:0]       s_cnt_q, s_cnt_d;
  logic [IDX_W-1:0] hw_q, hw_d, tmp_q, tmp_d, flat_q, flat_d;
  logic [IDX_W-1:0] aa_q, aa_d, wa_q, wa_d, arow_q, arow_d, achan_q, achan_d;
  logic             iss_q, iss_d, inr_q, inr_d;

  // Index multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [IDX_W-1:0]   mul_lo;

  // Handshake and store signals
  logic             in_acc, out_acc, out_load;
  logic             act_we, wgt_we;
  logic [7:0]       act_rd, wgt_rd;
  mac_ctl_t         mac_ctl;
  logic signed [31:0] mac_acc;
  logic             mac_busy;
  logic             out_vld_q, out_vld_d;
  out_item_t        out_q, out_d;

  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_vld_q & ~out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= CH_RST;
      ht_q  <= H_RST;
      wd_q  <= W_RST;
      flt_q <= M_RST;
      kr_q  <= R_RST;
      kc_q  <= S_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IN_CHANNELS: ch_q  <= cfg_data_i[4:0];
        REG_IN_HEIGHT:   ht_q  <= cfg_data_i[5:0];
        REG_IN_WIDTH:    wd_q  <= cfg_data_i[5:0];
        REG_FILTERS:     flt_q <= cfg_data_i[4:0];
        REG_KERNEL_ROWS: kr_q  <= cfg_data_i[2:0];
        REG_KERNEL_COLS: kc_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Saturate dimensions and check request bounds
  always_comb begin
    c_sat  = (int'(ch_q)  > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : ch_q;
    m_sat  = (int'(flt_q) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : flt_q;
    h_sat  = (int'(ht_q)  > MAX_DIM)      ? 6'(MAX_DIM)      : ht_q;
    w_sat  = (int'(wd_q)  > MAX_DIM)      ? 6'(MAX_DIM)      : wd_q;
    r_sat  = (int'(kr_q)  > MAX_KERNEL)   ? 3'(MAX_KERNEL)   : kr_q;
    s_sat  = (int'(kc_q)  > MAX_KERNEL)   ? 3'(MAX_KERNEL)   : kc_q;
    cfg_ok = (c_sat != '0) && (m_sat != '0) && (h_sat != '0) && (w_sat != '0) &&
             (r_sat != '0) && (s_sat != '0) &&
             ({3'd0, r_sat} <= h_sat) && ({3'd0, s_sat} <= w_sat);
    p_dim  = cfg_ok ? (h_sat - {3'd0, r_sat} + 6'd1) : '0;
    q_dim  = cfg_ok ? (w_sat - {3'd0, s_sat} + 6'd1) : '0;
    req_ok = cfg_ok && ({1'b0, in_item_i.out_filter} < m_sat) &&
             ({1'b0, in_item_i.out_row} < p_dim) &&
             ({1'b0, in_item_i.out_col} < q_dim);
  end

  // Select operands of the index multiplier per setup step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_HW:    begin mul_a = MUL_W'(h_sat);            mul_b = MUL_W'(w_sat);  end
      ST_RS:    begin mul_a = MUL_W'(r_sat);            mul_b = MUL_W'(s_sat);  end
      ST_CRS:   begin mul_a = MUL_W'(c_sat);            mul_b = MUL_W'(tmp_q);  end
      ST_WBASE: begin mul_a = MUL_W'(req_q.out_filter); mul_b = MUL_W'(tmp_q);  end
      ST_PQ:    begin mul_a = MUL_W'(p_dim);            mul_b = MUL_W'(q_dim);  end
      ST_FLAT:  begin mul_a = MUL_W'(req_q.out_filter); mul_b = MUL_W'(tmp_q);  end
      ST_PQOFF: begin mul_a = MUL_W'(req_q.out_row);    mul_b = MUL_W'(q_dim);  end
      ST_PW:    begin mul_a = MUL_W'(req_q.out_row);    mul_b = MUL_W'(w_sat);  end
      default:  begin mul_a = '0;                       mul_b = '0;             end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign mul_lo = mul_p[IDX_W-1:0];

  // Sequence setup, tap walk, drain and result hand-off
  always_comb begin
    state_d = state_q;
    ok_d    = ok_q;
    c_cnt_d = c_cnt_q;
    r_cnt_d = r_cnt_q;
    s_cnt_d = s_cnt_q;
    hw_d    = hw_q;
    tmp_d   = tmp_q;
    flat_d  = flat_q;
    aa_d    = aa_q;
    wa_d    = wa_q;
    arow_d  = arow_q;
    achan_d = achan_q;
    iss_d   = 1'b0;
    inr_d   = 1'b0;
    out_load = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.valid = iss_q & inr_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_item_i.action == ACT_COMPUTE) begin
          ok_d          = req_ok;
          c_cnt_d       = '0;
          r_cnt_d       = '0;
          s_cnt_d       = '0;
          mac_ctl.clear = 1'b1;
          state_d       = req_ok ? ST_HW : ST_FIN;
        end
      end
      ST_HW: begin
        hw_d    = mul_lo;
        state_d = ST_RS;
      end
      ST_RS: begin
        tmp_d   = mul_lo;
        state_d = ST_CRS;
      end
      ST_CRS: begin
        tmp_d   = mul_lo;
        state_d = ST_WBASE;
      end
      ST_WBASE: begin
        wa_d    = mul_lo;
        state_d = ST_PQ;
      end
      ST_PQ: begin
        tmp_d   = mul_lo;
        state_d = ST_FLAT;
      end
      ST_FLAT: begin
        flat_d  = mul_lo;
        state_d = ST_PQOFF;
      end
      ST_PQOFF: begin
        flat_d  = flat_q + mul_lo + IDX_W'(req_q.out_col);
        state_d = ST_PW;
      end
      ST_PW: begin
        aa_d    = mul_lo + IDX_W'(req_q.out_col);
        arow_d  = aa_d;
        achan_d = aa_d;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        // Issue one tap read, then advance column, row and channel
        iss_d = 1'b1;
        inr_d = (int'(aa_q) < ACT_DEPTH) && (int'(wa_q) < WGT_DEPTH);
        wa_d  = wa_q + IDX_W'(1);
        if (s_cnt_q != s_sat - 3'd1) begin
          s_cnt_d = s_cnt_q + 3'd1;
          aa_d    = aa_q + IDX_W'(1);
        end else begin
          s_cnt_d = '0;
          if (r_cnt_q != r_sat - 3'd1) begin
            r_cnt_d = r_cnt_q + 3'd1;
            arow_d  = arow_q + IDX_W'(w_sat);
            aa_d    = arow_d;
          end else begin
            r_cnt_d = '0;
            if (c_cnt_q != c_sat - 5'd1) begin
              c_cnt_d = c_cnt_q + 5'd1;
              achan_d = achan_q + hw_q;
              arow_d  = achan_d;
              aa_d    = achan_d;
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!iss_q && !mac_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Build the result item
  always_comb begin
    out_d.sum        = ok_q ? mac_acc : '0;
    out_d.flat_index = ok_q ? flat_q[13:0] : '0;
    out_d.request_ok = ok_q;
  end

  // Hold the output until taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_acc) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ok_q      <= 1'b0;
      c_cnt_q   <= '0;
      r_cnt_q   <= '0;
      s_cnt_q   <= '0;
      iss_q     <= 1'b0;
      inr_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ok_q      <= ok_d;
      c_cnt_q   <= c_cnt_d;
      r_cnt_q   <= r_cnt_d;
      s_cnt_q   <= s_cnt_d;
      iss_q     <= iss_d;
      inr_q     <= inr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_item_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    hw_q    <= hw_d;
    tmp_q   <= tmp_d;
    flat_q  <= flat_d;
    aa_q    <= aa_d;
    wa_q    <= wa_d;
    arow_q  <= arow_d;
    achan_q <= achan_d;
  end

  // Store writes, dropped beyond the store depth
  assign act_we = in_acc && (in_item_i.action == ACT_WRITE_ACT) &&
                  (int'(in_item_i.store_addr) < ACT_DEPTH);
  assign wgt_we = in_acc && (in_item_i.action == ACT_WRITE_WGT) &&
                  (int'(in_item_i.store_addr) < WGT_DEPTH);

  i8conv_ram #(
    .WIDTH (8),
    .DEPTH (ACT_DEPTH)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (ACT_AW'(in_item_i.store_addr)),
    .wdata_i (in_item_i.store_value),
    .raddr_i (ACT_AW'(aa_q)),
    .rdata_o (act_rd)
  );

  i8conv_ram #(
    .WIDTH (8),
    .DEPTH (WGT_DEPTH)
  ) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (WGT_AW'(in_item_i.store_addr)),
    .wdata_i (in_item_i.store_value),
    .raddr_i (WGT_AW'(wa_q)),
    .rdata_o (wgt_rd)
  );

  i8conv_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .act_i  (act_rd),
    .wgt_i  (wgt_rd),
    .acc_o  (mac_acc),
    .busy_o (mac_busy)
  );

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### rtl/i8conv_chk.sv
// Port-level checker of the convolution core and its bind to the top level.
`default_nettype none

module i8conv_chk
  import i8conv_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire in_item_t              in_item_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire out_item_t             out_item_o,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Rejected request returns zero sum and zero index
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.request_ok |->
      out_item_o.sum == '0 && out_item_o.flat_index == '0)
    else $error("invalid request returned nonzero fields");

  // Compute item busies the input
  a_comp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.action == ACT_COMPUTE |=> in_stall_o)
    else $error("input not stalled after compute item");

  // Store write leaves the input free for the next item
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_item_i.action == ACT_WRITE_ACT || in_item_i.action == ACT_WRITE_WGT)
    |=> !in_stall_o)
    else $error("input stalled after store write");

  // Configuration always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind int8_direct_convolution_core i8conv_chk u_i8conv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
